### rtl/quaternion_vector_rotation_unit_macros.svh
// Assertion macros for the quaternion vector rotation unit checker.
`ifndef QUATERNION_VECTOR_ROTATION_UNIT_MACROS_SVH
`define QUATERNION_VECTOR_ROTATION_UNIT_MACROS_SVH

// Same-cycle implication.
`define QVR_ASSERT_IMPL(label, clock, reset, ante, cons) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
    else $error("qvr check failed");

// Next-cycle implication.
`define QVR_ASSERT_NEXT(label, clock, reset, ante, cons) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
    else $error("qvr check failed");

`endif

### rtl/qvr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qvr_pkg
// Widths, payload types and shared constants of the quaternion rotation unit.
// ----------------------------------------------------------------------------
package qvr_pkg;

  localparam int QUAT_W = 16;
  localparam int VEC_W  = 24;
  localparam int DEN_W  = 2 * QUAT_W + 1;          // squared norm
  localparam int NUM_W  = 2 * QUAT_W + VEC_W + 2;  // rotated numerator
  localparam int QBITS  = VEC_W + 2;               // quotient bits
  localparam int NUMER_STAGES = 4;

  typedef logic signed [QUAT_W-1:0] quat_t;
  typedef logic signed [VEC_W-1:0]  vec_t;
  typedef logic signed [NUM_W-1:0]  num_t;
  typedef logic        [DEN_W-1:0]  den_t;

  typedef struct packed {
    quat_t quat_w;
    quat_t quat_x;
    quat_t quat_y;
    quat_t quat_z;
    vec_t  vec_x;
    vec_t  vec_y;
    vec_t  vec_z;
  } qvr_in_t;

  typedef struct packed {
    vec_t out_x;
    vec_t out_y;
    vec_t out_z;
  } qvr_out_t;

  // numerators and shared divisor handed from the product pipe to the divider
  typedef struct packed {
    num_t nx;
    num_t ny;
    num_t nz;
    den_t den;
  } qvr_frac_t;

endpackage

### rtl/quaternion_vector_rotation_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quaternion_vector_rotation_unit
// Rotates a Q15.8 vector by a normalized Q1.14 quat, one per unstalled cycle.
// ----------------------------------------------------------------------------
//  channel | dir | handshake            | payload
//  req     | in  | req_valid/req_stall  | qvr_in_t  (quaternion, vector)
//  rsp     | out | rsp_valid/rsp_stall  | qvr_out_t (rotated vector)
//
//  One transfer per cycle in both directions when rsp is not stalled.
//  Pipeline: 4 product stages, 1 rounding prep, 26 divider bits
//  (one restoring step per stage), 1 saturation/output register.
//  Reset (rst, synchronous) clears all valid bits; data registers keep junk.
//  A stalled rsp transfer freezes the whole pipe; req_stall follows it.
// ----------------------------------------------------------------------------
module quaternion_vector_rotation_unit (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_stall,
  input  qvr_pkg::qvr_in_t  req_data,
  output logic              rsp_valid,
  input  logic              rsp_stall,
  output qvr_pkg::qvr_out_t rsp_data
);
  import qvr_pkg::*;

  logic      advance;
  logic      frac_valid;
  qvr_frac_t frac;

  // the pipe moves unless a finished result is held by the consumer
  assign advance   = !(rsp_valid && rsp_stall);
  assign req_stall = !advance;

  // numerators of q*p*conj(q) and squared norm
  qvr_numer u_numer (
    .clk       (clk),
    .rst       (rst),
    .en        (advance),
    .in_valid  (req_valid),
    .in_data   (req_data),
    .out_valid (frac_valid),
    .out_frac  (frac)
  );

  // divide by the squared norm: the normalization, rounded once
  qvr_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (advance),
    .in_valid  (frac_valid),
    .in_frac   (frac),
    .out_valid (rsp_valid),
    .out_data  (rsp_data)
  );

endmodule

### rtl/qvr_numer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qvr_numer
// Four-stage product pipe: q * p * conj(q) numerators and squared norm.
// ----------------------------------------------------------------------------
module qvr_numer (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_valid,
  input  qvr_pkg::qvr_in_t   in_data,
  output logic               out_valid,
  output qvr_pkg::qvr_frac_t out_frac
);
  import qvr_pkg::*;

  localparam int SQ_W = 2 * QUAT_W;
  localparam int SW   = 2 * QUAT_W + 2;
  localparam int PV_W = QUAT_W + VEC_W;
  localparam int D_W  = QUAT_W + VEC_W + 2;
  localparam int C_W  = QUAT_W + VEC_W + 1;

  logic [NUMER_STAGES-1:0] valid;

  // stage 1: squares and quaternion-vector products
  logic signed [SQ_W-1:0] sq_w, sq_x, sq_y, sq_z;
  logic signed [PV_W-1:0] p_xvx, p_yvy, p_zvz, p_yvz, p_zvy, p_zvx, p_xvz, p_xvy, p_yvx;
  quat_t w1, x1, y1, z1;
  vec_t  vx1, vy1, vz1;

  // stage 2: norm, scalar term, dot and cross
  den_t                   n2;
  logic signed [DEN_W-1:0] s2;
  logic signed [D_W-1:0]  d2;
  logic signed [C_W-1:0]  cx2, cy2, cz2;
  quat_t w2, x2, y2, z2;
  vec_t  vx2, vy2, vz2;
  logic signed [SW-1:0]   usq, n2_full, s_full;

  // stage 3: second products
  num_t ts_x, ts_y, ts_z, td_x, td_y, td_z, tc_x, tc_y, tc_z;
  den_t n2_3;
  logic zero3;
  vec_t vx3, vy3, vz3;

  // stage 4 combinational sums
  num_t nx_next, ny_next, nz_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (en) begin
      valid <= {valid[NUMER_STAGES-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_w  <= in_data.quat_w * in_data.quat_w;
      sq_x  <= in_data.quat_x * in_data.quat_x;
      sq_y  <= in_data.quat_y * in_data.quat_y;
      sq_z  <= in_data.quat_z * in_data.quat_z;
      p_xvx <= in_data.quat_x * in_data.vec_x;
      p_yvy <= in_data.quat_y * in_data.vec_y;
      p_zvz <= in_data.quat_z * in_data.vec_z;
      p_yvz <= in_data.quat_y * in_data.vec_z;
      p_zvy <= in_data.quat_z * in_data.vec_y;
      p_zvx <= in_data.quat_z * in_data.vec_x;
      p_xvz <= in_data.quat_x * in_data.vec_z;
      p_xvy <= in_data.quat_x * in_data.vec_y;
      p_yvx <= in_data.quat_y * in_data.vec_x;
      w1 <= in_data.quat_w;
      x1 <= in_data.quat_x;
      y1 <= in_data.quat_y;
      z1 <= in_data.quat_z;
      vx1 <= in_data.vec_x;
      vy1 <= in_data.vec_y;
      vz1 <= in_data.vec_z;
    end
  end

  always_comb begin
    usq     = SW'(sq_x) + SW'(sq_y) + SW'(sq_z);
    n2_full = SW'(sq_w) + usq;
    s_full  = SW'(sq_w) - usq;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n2  <= DEN_W'(n2_full);
      s2  <= DEN_W'(s_full);
      d2  <= D_W'(p_xvx) + D_W'(p_yvy) + D_W'(p_zvz);
      cx2 <= C_W'(p_yvz) - C_W'(p_zvy);
      cy2 <= C_W'(p_zvx) - C_W'(p_xvz);
      cz2 <= C_W'(p_xvy) - C_W'(p_yvx);
      w2 <= w1;
      x2 <= x1;
      y2 <= y1;
      z2 <= z1;
      vx2 <= vx1;
      vy2 <= vy1;
      vz2 <= vz1;
    end
  end

  // terms wrap at NUM_W; the final sum is known to fit
  always_ff @(posedge clk) begin
    if (en) begin
      ts_x <= NUM_W'(s2 * vx2);
      ts_y <= NUM_W'(s2 * vy2);
      ts_z <= NUM_W'(s2 * vz2);
      td_x <= NUM_W'(d2 * x2);
      td_y <= NUM_W'(d2 * y2);
      td_z <= NUM_W'(d2 * z2);
      tc_x <= NUM_W'(w2 * cx2);
      tc_y <= NUM_W'(w2 * cy2);
      tc_z <= NUM_W'(w2 * cz2);
      n2_3  <= n2;
      zero3 <= (n2 == '0);
      vx3 <= vx2;
      vy3 <= vy2;
      vz3 <= vz2;
    end
  end

  always_comb begin
    nx_next = ts_x + (td_x <<< 1) + (tc_x <<< 1);
    ny_next = ts_y + (td_y <<< 1) + (tc_y <<< 1);
    nz_next = ts_z + (td_z <<< 1) + (tc_z <<< 1);
  end

  // zero quaternion: vector over a unit divisor gives it back unchanged
  always_ff @(posedge clk) begin
    if (en) begin
      if (zero3) begin
        out_frac.nx  <= NUM_W'(vx3);
        out_frac.ny  <= NUM_W'(vy3);
        out_frac.nz  <= NUM_W'(vz3);
        out_frac.den <= DEN_W'(1);
      end else begin
        out_frac.nx  <= nx_next;
        out_frac.ny  <= ny_next;
        out_frac.nz  <= nz_next;
        out_frac.den <= n2_3;
      end
    end
  end

  assign out_valid = valid[NUMER_STAGES-1];

endmodule

### rtl/qvr_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qvr_div
// Three-lane pipelined restoring divider, round to nearest, saturate.
// ----------------------------------------------------------------------------
module qvr_div (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_valid,
  input  qvr_pkg::qvr_frac_t in_frac,
  output logic               out_valid,
  output qvr_pkg::qvr_out_t  out_data
);
  import qvr_pkg::*;

  localparam int LANES = 3;
  localparam logic [QBITS-1:0] POS_MAX = QBITS'((1 << (VEC_W - 1)) - 1);
  localparam logic [QBITS-1:0] NEG_MAX = QBITS'(1 << (VEC_W - 1));

  typedef logic [NUM_W-1:0] rem_t;
  typedef logic [QBITS-1:0] quo_t;

  // index 0 is the prep stage output, index i+1 after quotient bit i
  rem_t rem   [QBITS+1][LANES];
  quo_t quo   [QBITS+1][LANES];
  logic neg   [QBITS+1][LANES];
  den_t den   [QBITS+1];
  logic valid [QBITS+2];

  num_t num_in [LANES];
  vec_t res    [LANES];

  assign num_in[0] = in_frac.nx;
  assign num_in[1] = in_frac.ny;
  assign num_in[2] = in_frac.nz;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < QBITS + 2; i++) valid[i] <= 1'b0;
    end else if (en) begin
      valid[0] <= in_valid;
      for (int i = 1; i < QBITS + 2; i++) valid[i] <= valid[i-1];
    end
  end

  // prep: |n| + den/2 in one adder, carry-in completes the negate
  always_ff @(posedge clk) begin
    if (en) begin
      den[0] <= in_frac.den;
      for (int l = 0; l < LANES; l++) begin
        neg[0][l] <= num_in[l][NUM_W-1];
        quo[0][l] <= '0;
        rem[0][l] <= (num_in[l][NUM_W-1] ? ~rem_t'(num_in[l]) : rem_t'(num_in[l]))
                     + rem_t'(in_frac.den >> 1) + rem_t'(num_in[l][NUM_W-1]);
      end
    end
  end

  for (genvar i = 0; i < QBITS; i++) begin : g_bit
    localparam int K = QBITS - 1 - i;
    logic [NUM_W:0] trial [LANES];

    always_comb begin
      for (int l = 0; l < LANES; l++) begin
        trial[l] = {1'b0, rem[i][l]} - ((NUM_W + 1)'(den[i]) << K);
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        den[i+1] <= den[i];
        for (int l = 0; l < LANES; l++) begin
          neg[i+1][l] <= neg[i][l];
          quo[i+1][l] <= {quo[i][l][QBITS-2:0], ~trial[l][NUM_W]};
          rem[i+1][l] <= trial[l][NUM_W] ? rem[i][l] : trial[l][NUM_W-1:0];
        end
      end
    end
  end

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      if (neg[QBITS][l]) begin
        res[l] = (quo[QBITS][l] > NEG_MAX) ? vec_t'(NEG_MAX) : vec_t'(-quo[QBITS][l]);
      end else begin
        res[l] = (quo[QBITS][l] > POS_MAX) ? vec_t'(POS_MAX) : vec_t'(quo[QBITS][l]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data.out_x <= res[0];
      out_data.out_y <= res[1];
      out_data.out_z <= res[2];
    end
  end

  assign out_valid = valid[QBITS+1];

endmodule

### rtl/qvr_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qvr_checker
// Port-level checks of the rotation unit, bound to the top level.
// ----------------------------------------------------------------------------
`include "quaternion_vector_rotation_unit_macros.svh"

module qvr_checker (
  input logic              clk,
  input logic              rst,
  input logic              req_stall,
  input logic              rsp_valid,
  input logic              rsp_stall,
  input qvr_pkg::qvr_out_t rsp_data
);

  `QVR_ASSERT_NEXT(a_rsp_hold, clk, rst, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data))
  `QVR_ASSERT_IMPL(a_stall_src, clk, rst, req_stall, rsp_valid && rsp_stall)
  `QVR_ASSERT_IMPL(a_no_stall, clk, rst, !(rsp_valid && rsp_stall), !req_stall)
  `QVR_ASSERT_NEXT(a_rst_empty, clk, 1'b0, rst, !rsp_valid)

endmodule

bind quaternion_vector_rotation_unit qvr_checker u_qvr_checker (.*);
